[rtl/owtr_pkg.sv]
`default_nettype none

package owtr_pkg;

   // Width of the tick counter; an interval also ends once the counter reaches its all-ones value.
   localparam int COUNT_WIDTH = 20;
   localparam int WAIT_WIDTH  = 20;
   localparam int CMP_WIDTH   = ((COUNT_WIDTH > WAIT_WIDTH) ? COUNT_WIDTH : WAIT_WIDTH) + 1;

   localparam int INDEX_WIDTH = 3;
   localparam int DATA_WIDTH  = 20;

   // Register indexes on the configuration port.
   localparam logic [INDEX_WIDTH-1:0] REG_RESET_LOW     = 3'd0;
   localparam logic [INDEX_WIDTH-1:0] REG_RESET_RELEASE = 3'd1;
   localparam logic [INDEX_WIDTH-1:0] REG_SLOT          = 3'd2;
   localparam logic [INDEX_WIDTH-1:0] REG_WRITE_ZERO    = 3'd3;
   localparam logic [INDEX_WIDTH-1:0] REG_SHORT_LOW     = 3'd4;
   localparam logic [INDEX_WIDTH-1:0] REG_SAMPLE        = 3'd5;
   localparam logic [INDEX_WIDTH-1:0] REG_CONV_WAIT     = 3'd6;

   // Bus commands.
   localparam logic [7:0] CMD_SKIP_ROM        = 8'hCC;
   localparam logic [7:0] CMD_CONVERT         = 8'h44;
   localparam logic [7:0] CMD_READ_SCRATCHPAD = 8'hBE;

   typedef struct packed {
      logic [9:0]            reset_low_ticks;
      logic [9:0]            reset_release_ticks;
      logic [7:0]            slot_ticks;
      logic [7:0]            write_zero_low_ticks;
      logic [7:0]            short_low_ticks;
      logic [7:0]            sample_tick;
      logic [WAIT_WIDTH-1:0] conversion_wait_ticks;
   } owtr_cfg_type;

   typedef enum logic [4:0] {
      PH_RESET_LOW  = 5'b00001,
      PH_RESET_WAIT = 5'b00010,
      PH_WRITE      = 5'b00100,
      PH_CONV_WAIT  = 5'b01000,
      PH_READ       = 5'b10000
   } owtr_phase_type;

endpackage

`default_nettype wire

[rtl/owtr_req_if.sv]
`default_nettype none

interface owtr_req_if;
   logic valid;
   logic ready;
   logic bus_level;

   modport source (output valid, output bus_level, input ready);
   modport sink (input valid, input bus_level, output ready);
endinterface

`default_nettype wire

[rtl/owtr_rsp_if.sv]
`default_nettype none

interface owtr_rsp_if;
   logic        valid;
   logic        ready;
   logic        drive_low;
   logic        reading_valid;
   logic [15:0] raw_reading;
   logic [15:0] temperature_tenths;

   modport source (output valid, output drive_low, output reading_valid,
                   output raw_reading, output temperature_tenths, input ready);
   modport sink (input valid, input drive_low, input reading_valid,
                 input raw_reading, input temperature_tenths, output ready);
endinterface

`default_nettype wire

[rtl/owtr_regs.sv]
`default_nettype none

module owtr_regs
   import owtr_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_en,
   input  wire logic [INDEX_WIDTH-1:0] csr_index,
   input  wire logic [DATA_WIDTH-1:0]  csr_data,
   output owtr_cfg_type                cfg
);

   owtr_cfg_type cfg_ff;
   owtr_cfg_type cfg_in;

   // Each write keeps only the low bits that fit the addressed register.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_RESET_LOW:     cfg_in.reset_low_ticks       = csr_data[9:0];
            REG_RESET_RELEASE: cfg_in.reset_release_ticks   = csr_data[9:0];
            REG_SLOT:          cfg_in.slot_ticks            = csr_data[7:0];
            REG_WRITE_ZERO:    cfg_in.write_zero_low_ticks  = csr_data[7:0];
            REG_SHORT_LOW:     cfg_in.short_low_ticks       = csr_data[7:0];
            REG_SAMPLE:        cfg_in.sample_tick           = csr_data[7:0];
            REG_CONV_WAIT:     cfg_in.conversion_wait_ticks = csr_data[WAIT_WIDTH-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_ticks       <= 10'd480;
         cfg_ff.reset_release_ticks   <= 10'd480;
         cfg_ff.slot_ticks            <= 8'd70;
         cfg_ff.write_zero_low_ticks  <= 8'd60;
         cfg_ff.short_low_ticks       <= 8'd6;
         cfg_ff.sample_tick           <= 8'd12;
         cfg_ff.conversion_wait_ticks <= WAIT_WIDTH'(750000);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[rtl/one_wire_thermometer_reader.sv]
`default_nettype none

// Channel   Port         Direction  Beat contents
// --------  -----------  ---------  -----------------------------------------------
// request   req_bus      in         bus_level: sampled line level for one tick
// response  rsp_bus      out        drive_low, reading_valid, raw_reading, tenths
// config    csr_*        in         write enable, register index, write data
//
// Every request beat is one bus tick and yields exactly one response beat.
// The sequencer takes one beat per cycle; the response sits in one output
// register, so a beat is taken whenever that register is empty or being drained.
// The response is registered and valid in the cycle after its beat is accepted.
// Synchronous reset returns the sequencer to the reset pulse of a convert pass
// and loads the default timing registers.
// A stalled response blocks new request beats; no state advances without a beat.

module one_wire_thermometer_reader
   import owtr_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   owtr_req_if.sink                    req_bus,
   owtr_rsp_if.source                  rsp_bus,
   input  wire logic                   csr_write_en,
   input  wire logic [INDEX_WIDTH-1:0] csr_index,
   input  wire logic [DATA_WIDTH-1:0]  csr_data
);

   owtr_cfg_type cfg;

   owtr_regs u_regs (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cfg          (cfg)
   );

   // Sequencer state.
   owtr_phase_type         phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] tick_count_ff, tick_count_in;
   logic [3:0]             bit_index_ff, bit_index_in;
   logic                   command_step_ff, command_step_in;
   logic [7:0]             send_shift_ff, send_shift_in;
   logic [15:0]            receive_shift_ff, receive_shift_in;
   logic [15:0]            last_raw_ff, last_raw_in;
   logic [15:0]            last_tenths_ff, last_tenths_in;
   logic                   read_pass_ff, read_pass_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_drive_ff;
   logic        rsp_reading_ff;
   logic [15:0] rsp_raw_ff;
   logic [15:0] rsp_tenths_ff;

   logic accept;
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   // Timing helpers shared by all phases.
   logic [CMP_WIDTH-1:0] tick_ext;
   logic [CMP_WIDTH-1:0] tick_plus;
   logic [CMP_WIDTH-1:0] interval_len;
   logic [7:0]           slot_len;
   logic [7:0]           write_low;
   logic [7:0]           sample_at;
   logic                 count_full;
   logic                 done;
   logic                 drive;
   logic                 reading_done;
   logic [3:0]           bit_next;
   logic [19:0]          times_ten;

   assign tick_ext   = CMP_WIDTH'(tick_count_ff);
   assign tick_plus  = tick_ext + CMP_WIDTH'(1);
   assign count_full = (tick_count_ff == {COUNT_WIDTH{1'b1}});
   assign slot_len   = (cfg.slot_ticks == 8'd0) ? 8'd1 : cfg.slot_ticks;
   assign write_low  = send_shift_ff[0] ? cfg.short_low_ticks : cfg.write_zero_low_ticks;
   // A sample point past the slot end is taken on the slot's last tick.
   assign sample_at  = (cfg.sample_tick < slot_len) ? cfg.sample_tick : slot_len - 8'd1;
   assign bit_next   = bit_index_ff + 4'd1;

   always_comb begin
      case (phase_ff)
         PH_RESET_LOW:  interval_len = CMP_WIDTH'(cfg.reset_low_ticks);
         PH_RESET_WAIT: interval_len = CMP_WIDTH'(cfg.reset_release_ticks);
         PH_CONV_WAIT:  interval_len = CMP_WIDTH'(cfg.conversion_wait_ticks);
         default:       interval_len = CMP_WIDTH'(slot_len);
      endcase
   end

   // A zero length ends on the first tick, as does a saturated counter.
   assign done = (tick_plus >= interval_len) || count_full;

   // Reading of sixteen bits scaled to tenths: (raw * 10 + 8) >> 4.
   assign times_ten = {1'b0, receive_shift_in, 3'b000} + {3'b000, receive_shift_in, 1'b0}
                      + 20'd8;

   always_comb begin
      phase_in         = phase_ff;
      bit_index_in     = bit_index_ff;
      command_step_in  = command_step_ff;
      send_shift_in    = send_shift_ff;
      receive_shift_in = receive_shift_ff;
      read_pass_in     = read_pass_ff;
      drive            = 1'b0;
      reading_done     = 1'b0;
      case (phase_ff)
         PH_RESET_LOW: begin
            drive = 1'b1;
            if (done) begin
               phase_in = PH_RESET_WAIT;
            end
         end
         PH_RESET_WAIT: begin
            if (done) begin
               phase_in        = PH_WRITE;
               command_step_in = 1'b0;
               bit_index_in    = 4'd0;
               send_shift_in   = CMD_SKIP_ROM;
            end
         end
         PH_WRITE: begin
            drive = (tick_ext < CMP_WIDTH'(write_low));
            if (done) begin
               send_shift_in = {1'b0, send_shift_ff[7:1]};
               bit_index_in  = bit_next;
               if (bit_next[3]) begin
                  bit_index_in = 4'd0;
                  if (!command_step_ff) begin
                     command_step_in = 1'b1;
                     send_shift_in   = read_pass_ff ? CMD_READ_SCRATCHPAD : CMD_CONVERT;
                  end else begin
                     command_step_in  = 1'b0;
                     receive_shift_in = 16'd0;
                     phase_in         = read_pass_ff ? PH_READ : PH_CONV_WAIT;
                  end
               end
            end
         end
         PH_CONV_WAIT: begin
            if (done) begin
               read_pass_in = 1'b1;
               phase_in     = PH_RESET_LOW;
            end
         end
         PH_READ: begin
            drive = (tick_ext < CMP_WIDTH'(cfg.short_low_ticks));
            if (tick_ext == CMP_WIDTH'(sample_at)) begin
               receive_shift_in = {req_bus.bus_level, receive_shift_ff[15:1]};
            end
            if (done) begin
               bit_index_in = bit_next;
               if (bit_next == 4'd0) begin
                  reading_done = 1'b1;
                  read_pass_in = 1'b0;
                  phase_in     = PH_RESET_LOW;
               end
            end
         end
         default: begin
            phase_in = PH_RESET_LOW;
         end
      endcase
   end

   // An unknown phase code also clears the counter, like the end of an interval.
   always_comb begin
      if (done || !((phase_ff == PH_RESET_LOW) || (phase_ff == PH_RESET_WAIT) ||
                    (phase_ff == PH_WRITE) || (phase_ff == PH_CONV_WAIT) ||
                    (phase_ff == PH_READ))) begin
         tick_count_in = '0;
      end else begin
         tick_count_in = tick_plus[COUNT_WIDTH-1:0];
      end
   end

   assign last_raw_in    = reading_done ? receive_shift_in : last_raw_ff;
   assign last_tenths_in = reading_done ? times_ten[19:4] : last_tenths_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_RESET_LOW;
         tick_count_ff    <= '0;
         bit_index_ff     <= 4'd0;
         command_step_ff  <= 1'b0;
         send_shift_ff    <= 8'd0;
         receive_shift_ff <= 16'd0;
         last_raw_ff      <= 16'd0;
         last_tenths_ff   <= 16'd0;
         read_pass_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff         <= phase_in;
            tick_count_ff    <= tick_count_in;
            bit_index_ff     <= bit_index_in;
            command_step_ff  <= command_step_in;
            send_shift_ff    <= send_shift_in;
            receive_shift_ff <= receive_shift_in;
            last_raw_ff      <= last_raw_in;
            last_tenths_ff   <= last_tenths_in;
            read_pass_ff     <= read_pass_in;
         end
      end
   end

   // The payload register loads on every accepted beat.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_drive_ff   <= drive;
         rsp_reading_ff <= reading_done;
         rsp_raw_ff     <= last_raw_in;
         rsp_tenths_ff  <= last_tenths_in;
      end
   end

   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.drive_low          = rsp_drive_ff;
   assign rsp_bus.reading_valid      = rsp_reading_ff;
   assign rsp_bus.raw_reading        = rsp_raw_ff;
   assign rsp_bus.temperature_tenths = rsp_tenths_ff;

endmodule

`default_nettype wire

[dv/owtr_tick_checker.sv]
module owtr_tick_checker
   import owtr_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   owtr_req_if                         req_mon,
   owtr_rsp_if                         rsp_mon,
   input  wire logic                   csr_write_en,
   input  wire logic [INDEX_WIDTH-1:0] csr_index,
   input  wire logic [DATA_WIDTH-1:0]  csr_data,
   output int unsigned                 failure_count,
   output int unsigned                 pending_beats
);

   typedef struct packed {
      logic        drive_low;
      logic        reading_valid;
      logic [15:0] raw_reading;
      logic [15:0] temperature_tenths;
   } bus_tick_type;

   // Shadow copy of the sequencer and its timing registers.
   owtr_cfg_type           cfg;
   owtr_phase_type         phase;
   logic [COUNT_WIDTH-1:0] tick_count;
   logic [3:0]             bit_index;
   logic                   command_step;
   logic [7:0]             send_shift;
   logic [15:0]            receive_shift;
   logic [15:0]            last_raw;
   logic [15:0]            last_tenths;
   logic                   read_pass;

   bus_tick_type           expected_ticks[$];
   int unsigned            fail_tally = 0;

   // An interval of length zero ends on its first tick, as a length of one would.
   function automatic logic span_done(input int unsigned len);
      int unsigned position;
      position = tick_count;
      return (position + 1 >= len) || (tick_count == '1);
   endfunction

   function automatic bus_tick_type next_bus_tick(input logic level);
      bus_tick_type beat;
      int unsigned  slot_len;
      logic [7:0]   low_len;
      int unsigned  sample_at;
      logic         done;
      logic [19:0]  tenths_wide;
      beat = '0;
      done = 1'b0;
      slot_len = (cfg.slot_ticks == 8'd0) ? 1 : cfg.slot_ticks;
      case (phase)
         PH_RESET_LOW: begin
            beat.drive_low = 1'b1;
            done = span_done(cfg.reset_low_ticks);
            if (done) phase = PH_RESET_WAIT;
         end
         PH_RESET_WAIT: begin
            done = span_done(cfg.reset_release_ticks);
            if (done) begin
               phase = PH_WRITE;
               command_step = 1'b0;
               bit_index = '0;
               send_shift = CMD_SKIP_ROM;
            end
         end
         PH_WRITE: begin
            low_len = send_shift[0] ? cfg.short_low_ticks : cfg.write_zero_low_ticks;
            beat.drive_low = (tick_count < low_len);
            done = span_done(slot_len);
            if (done) begin
               send_shift = send_shift >> 1;
               bit_index = bit_index + 4'd1;
               if (bit_index >= 4'd8) begin
                  bit_index = '0;
                  if (!command_step) begin
                     command_step = 1'b1;
                     send_shift = read_pass ? CMD_READ_SCRATCHPAD : CMD_CONVERT;
                  end else begin
                     command_step = 1'b0;
                     receive_shift = '0;
                     phase = read_pass ? PH_READ : PH_CONV_WAIT;
                  end
               end
            end
         end
         PH_CONV_WAIT: begin
            done = span_done(cfg.conversion_wait_ticks);
            if (done) begin
               read_pass = 1'b1;
               phase = PH_RESET_LOW;
            end
         end
         PH_READ: begin
            sample_at = (cfg.sample_tick < slot_len) ? cfg.sample_tick : slot_len - 1;
            beat.drive_low = (tick_count < cfg.short_low_ticks);
            if (tick_count == sample_at) receive_shift = {level, receive_shift[15:1]};
            done = span_done(slot_len);
            if (done) begin
               bit_index = bit_index + 4'd1;
               if (bit_index == 4'd0) begin
                  last_raw = receive_shift;
                  tenths_wide = {4'd0, last_raw} * 20'd10 + 20'd8;
                  last_tenths = tenths_wide[19:4];
                  beat.reading_valid = 1'b1;
                  read_pass = 1'b0;
                  phase = PH_RESET_LOW;
               end
            end
         end
         default: begin
            phase = PH_RESET_LOW;
            done = 1'b1;
         end
      endcase
      tick_count = done ? '0 : tick_count + 1'b1;
      beat.raw_reading = last_raw;
      beat.temperature_tenths = last_tenths;
      return beat;
   endfunction

   always @(posedge clock) begin
      bus_tick_type want;
      if (reset) begin
         cfg.reset_low_ticks = 10'd480;
         cfg.reset_release_ticks = 10'd480;
         cfg.slot_ticks = 8'd70;
         cfg.write_zero_low_ticks = 8'd60;
         cfg.short_low_ticks = 8'd6;
         cfg.sample_tick = 8'd12;
         cfg.conversion_wait_ticks = 20'd750000;
         phase = PH_RESET_LOW;
         tick_count = '0;
         bit_index = '0;
         command_step = 1'b0;
         send_shift = '0;
         receive_shift = '0;
         last_raw = '0;
         last_tenths = '0;
         read_pass = 1'b0;
         expected_ticks.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               REG_RESET_LOW:     cfg.reset_low_ticks = csr_data[9:0];
               REG_RESET_RELEASE: cfg.reset_release_ticks = csr_data[9:0];
               REG_SLOT:          cfg.slot_ticks = csr_data[7:0];
               REG_WRITE_ZERO:    cfg.write_zero_low_ticks = csr_data[7:0];
               REG_SHORT_LOW:     cfg.short_low_ticks = csr_data[7:0];
               REG_SAMPLE:        cfg.sample_tick = csr_data[7:0];
               REG_CONV_WAIT:     cfg.conversion_wait_ticks = csr_data[WAIT_WIDTH-1:0];
               default: begin
               end
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_ticks.size() == 0) begin
               $error("response beat arrived with no request beat outstanding");
               fail_tally++;
            end else begin
               want = expected_ticks.pop_front();
               if (rsp_mon.drive_low !== want.drive_low) begin
                  $error("drive_low: expected %0d, actual %0d", want.drive_low,
                         rsp_mon.drive_low);
                  fail_tally++;
               end
               if (rsp_mon.reading_valid !== want.reading_valid) begin
                  $error("reading_valid: expected %0d, actual %0d", want.reading_valid,
                         rsp_mon.reading_valid);
                  fail_tally++;
               end
               if (rsp_mon.raw_reading !== want.raw_reading) begin
                  $error("raw_reading: expected %0d, actual %0d", want.raw_reading,
                         rsp_mon.raw_reading);
                  fail_tally++;
               end
               if (rsp_mon.temperature_tenths !== want.temperature_tenths) begin
                  $error("temperature_tenths: expected %0d, actual %0d",
                         want.temperature_tenths, rsp_mon.temperature_tenths);
                  fail_tally++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_ticks.push_back(next_bus_tick(req_mon.bus_level));
         end
      end
      failure_count <= fail_tally;
      pending_beats <= expected_ticks.size();
   end

endmodule

[dv/tb_one_wire_thermometer_reader.sv]
module tb_one_wire_thermometer_reader;
   import owtr_pkg::*;

   // The register file decodes seven indexes; the eighth must be ignored.
   localparam logic [INDEX_WIDTH-1:0] REG_UNUSED = 3'd7;

   // The least number of random bus ticks to send after the directed phases.
   localparam int RANDOM_TICKS = 100;

   // Cycles with no accepted beat on either channel before the run is abandoned.
   // Legitimate quiet stretches come only from idling or a register load, so
   // this is far above anything a working block needs.
   localparam int STALL_LIMIT = 2000;

   // The response is registered behind its request; the drain cycles at the end
   // give any stray beat a chance to show up.
   localparam int DRAIN_CYCLES = 8;

   typedef enum {
      LEVEL_RANDOM,
      LEVEL_HIGH,
      LEVEL_LOW,
      LEVEL_TOGGLE
   } level_mode_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_en;
   logic [INDEX_WIDTH-1:0] csr_index;
   logic [DATA_WIDTH-1:0]  csr_data;

   // When set, neither the sender nor the receiver inserts idle cycles.
   bit                     no_stall;
   int unsigned            dead_cycles;
   int unsigned            failure_count;
   int unsigned            pending_beats;

   owtr_req_if req_bus ();
   owtr_rsp_if rsp_bus ();

   one_wire_thermometer_reader uut (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   // The checker sits beside the block, watches both channels and the register
   // port, and reports how many beats it still expects and how many failed.
   owtr_tick_checker tick_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .failure_count (failure_count),
      .pending_beats (pending_beats)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The receiver drops ready in about one cycle out of eight, except during a
   // stretch where the stimulus asks for back-to-back traffic.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= no_stall || ($urandom_range(99) >= 12);
      end
   end

   // Watchdog: any accepted beat on either side counts as progress.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         dead_cycles <= 0;
      end else if (dead_cycles + 1 >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         dead_cycles <= dead_cycles + 1;
      end
   end

   // Sends a number of bus ticks. Each tick is one request beat; the sender
   // idles at random between beats unless no_stall is set. A beat is held until
   // the block takes it, and valid drops only while idling and after the last one.
   task automatic send_ticks(input int count, input level_mode_type mode);
      int sent;
      sent = 0;
      while (sent < count) begin
         @(negedge clock);
         if (!no_stall && $urandom_range(99) < 12) begin
            req_bus.valid <= 1'b0;
         end else begin
            req_bus.valid <= 1'b1;
            case (mode)
               LEVEL_HIGH:   req_bus.bus_level <= 1'b1;
               LEVEL_LOW:    req_bus.bus_level <= 1'b0;
               LEVEL_TOGGLE: req_bus.bus_level <= sent[0];
               default:      req_bus.bus_level <= 1'($urandom_range(1));
            endcase
            do @(posedge clock); while (!req_bus.ready);
            sent++;
         end
      end
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   // Waits until every request beat sent so far has produced its response beat.
   // Each tick yields exactly one response, so the block is idle at that point.
   task automatic wait_drained();
      do @(posedge clock); while (pending_beats != 0);
   endtask

   // One register write per cycle; the caller lowers the enable afterwards.
   task automatic csr_write(input logic [INDEX_WIDTH-1:0] index,
                            input logic [DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_data <= data;
   endtask

   task automatic csr_release();
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Drains the block, loads a full timing set, then runs a stretch of ticks
   // with it. The sequencer keeps its place in the loop across the load, so
   // new timing often takes over in the middle of a slot or a wait.
   task automatic run_phase(input owtr_cfg_type timing, input int ticks,
                            input level_mode_type mode, input bit quiet);
      wait_drained();
      csr_write(REG_RESET_LOW, DATA_WIDTH'(timing.reset_low_ticks));
      csr_write(REG_RESET_RELEASE, DATA_WIDTH'(timing.reset_release_ticks));
      csr_write(REG_SLOT, DATA_WIDTH'(timing.slot_ticks));
      csr_write(REG_WRITE_ZERO, DATA_WIDTH'(timing.write_zero_low_ticks));
      csr_write(REG_SHORT_LOW, DATA_WIDTH'(timing.short_low_ticks));
      csr_write(REG_SAMPLE, DATA_WIDTH'(timing.sample_tick));
      csr_write(REG_CONV_WAIT, DATA_WIDTH'(timing.conversion_wait_ticks));
      csr_release();
      // The idling switch changes on a rising edge so that it never races the
      // receiver's falling-edge update.
      @(posedge clock);
      no_stall = quiet;
      send_ticks(ticks, mode);
   endtask

   initial begin
      owtr_cfg_type   timing;
      int             random_sent;
      int             span;
      int             pick;
      level_mode_type mode;

      req_bus.valid = 1'b0;
      req_bus.bus_level = 1'b0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_data = '0;
      no_stall = 1'b0;
      reset = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset timing as it comes out of reset: only the start of the long reset
      // pulse is visible, with the line toggling every tick.
      send_ticks(24, LEVEL_TOGGLE);

      // Every length written as zero. Each interval and slot then lasts a single
      // tick and no slot ever drives low, so a full loop takes about fifty
      // ticks. The line is held high to get an all-ones reading.
      timing = '0;
      run_phase(timing, 120, LEVEL_HIGH, 1'b0);

      // Low times at or beyond the slot length keep the bus low for the whole
      // slot, and a sample point past the end of the slot falls on its last
      // tick. The line is held low so the reading drops back to zero.
      timing.reset_low_ticks = 10'd2;
      timing.reset_release_ticks = 10'd3;
      timing.slot_ticks = 8'd3;
      timing.write_zero_low_ticks = 8'd200;
      timing.short_low_ticks = 8'd255;
      timing.sample_tick = 8'd250;
      timing.conversion_wait_ticks = 20'd5;
      run_phase(timing, 200, LEVEL_LOW, 1'b0);

      // Every register at its top value. The sequencer is then part way through a
      // write, so this covers long write slots, and runs back to back with no
      // idling on either side.
      timing.reset_low_ticks = 10'd1023;
      timing.reset_release_ticks = 10'd1023;
      timing.slot_ticks = 8'd255;
      timing.write_zero_low_ticks = 8'd255;
      timing.short_low_ticks = 8'd255;
      timing.sample_tick = 8'd255;
      timing.conversion_wait_ticks = 20'hFFFFF;
      run_phase(timing, 1100, LEVEL_RANDOM, 1'b1);

      // Register writes carry junk in the bits above each register's width,
      // and a write to the undecoded index must change nothing.
      wait_drained();
      @(posedge clock);
      no_stall = 1'b0;
      csr_write(REG_RESET_LOW, 20'hFFC03);
      csr_write(REG_RESET_RELEASE, 20'hABC02);
      csr_write(REG_SLOT, 20'h12305);
      csr_write(REG_WRITE_ZERO, 20'hFFF04);
      csr_write(REG_SHORT_LOW, 20'h00101);
      csr_write(REG_SAMPLE, 20'hF0F03);
      csr_write(REG_CONV_WAIT, 20'h00007);
      csr_write(REG_UNUSED, 20'hFFFFF);
      csr_release();
      send_ticks(150, LEVEL_RANDOM);

      // Random part: short timing sets so that full convert and read passes
      // come around often. Low times and the sample point sometimes exceed the
      // slot. Most stretches sample random line levels; some hold the line.
      random_sent = 0;
      while (random_sent < RANDOM_TICKS) begin
         timing.slot_ticks = 8'($urandom_range(6, 2));
         timing.reset_low_ticks = 10'($urandom_range(12, 1));
         timing.reset_release_ticks = 10'($urandom_range(12, 1));
         timing.write_zero_low_ticks = 8'($urandom_range(timing.slot_ticks + 1, 1));
         timing.short_low_ticks = 8'($urandom_range(timing.slot_ticks + 1, 1));
         timing.sample_tick = 8'($urandom_range(timing.slot_ticks + 1, 1));
         timing.conversion_wait_ticks = 20'($urandom_range(20, 1));
         pick = $urandom_range(99);
         if (pick < 70) begin
            mode = LEVEL_RANDOM;
         end else if (pick < 85) begin
            mode = LEVEL_HIGH;
         end else begin
            mode = LEVEL_LOW;
         end
         span = $urandom_range(150, 50);
         run_phase(timing, span, mode, 1'b0);
         random_sent += span;
      end

      // Let every outstanding response come back, then allow the drain cycles
      // for anything unexpected before giving the verdict.
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failure_count == 0 && pending_beats == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
